// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Defining NO_ASSERTIONS
// compiles every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge outside of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: hw/rtl/rtccsa_pkg.sv
// ----------------------------------------------------------------------------
// rtccsa_pkg
// Shared constants, command codes, register layout and calendar tables.
// ----------------------------------------------------------------------------
package rtccsa_pkg;

  // Register region size in bytes and derived word count
  localparam int REGION_BYTES = 64;
  localparam int WORD_COUNT   = (REGION_BYTES + 3) / 4;
  localparam int IDX_W        = $clog2(WORD_COUNT);

  // Transaction kinds (in_tuser)
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Word indexes
  localparam logic [IDX_W-1:0] IDX_CTRL  = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_SECS  = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_ALARM = IDX_W'(2);

  // Control bit positions
  localparam int BIT_EN   = 0;
  localparam int BIT_AE   = 2;
  localparam int BIT_AIE  = 3;
  localparam int BIT_AF   = 4;
  localparam int BIT_HZIE = 5;
  localparam int BIT_HZ   = 6;
  localparam int BIT_WRDY = 7;

  // Date conversion constants
  localparam logic [11:0] BASE_YEAR  = 12'd2000;
  localparam logic [31:0] DAYS_CYCLE = 32'd1461;   // 365 * 3 + 366
  localparam logic [31:0] HRS_DAY    = 32'd24;
  localparam logic [31:0] MIN_HR     = 32'd60;

  // Datapath step codes
  localparam logic [2:0] STEP_NONE = 3'd0;
  localparam logic [2:0] STEP_DAYS = 3'd1;
  localparam logic [2:0] STEP_HRS  = 3'd2;
  localparam logic [2:0] STEP_MIN  = 3'd3;
  localparam logic [2:0] STEP_SEC  = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;  // latch the accepted transaction
    logic [2:0] step;     // date conversion step
    logic       commit;   // apply item to register file, load result
  } dp_cmd_t;

  // Days before month, month index 0 = January
  function automatic logic [8:0] days_before_month(input logic [3:0] mi);
    logic [8:0] d;
    case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Days before a year within the four-year cycle (leap year first)
  function automatic logic [10:0] days_before_year(input logic [1:0] yi);
    logic [10:0] d;
    case (yi)
      2'd0:    d = 11'd0;
      2'd1:    d = 11'd366;
      2'd2:    d = 11'd731;
      default: d = 11'd1096;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/rtccsa_ctrl.sv
// ----------------------------------------------------------------------------
// rtccsa_ctrl
// Sequencer: accepts one transaction, steps the date conversion on ticks,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module rtccsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic [1:0]         in_cmd,
  output logic               in_tready,
  input  logic               out_tready,
  output logic               out_tvalid,
  output rtccsa_pkg::dp_cmd_t dp_cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DAYS = 3'd1;
  localparam logic [2:0] ST_HRS  = 3'd2;
  localparam logic [2:0] ST_MIN  = 3'd3;
  localparam logic [2:0] ST_SEC  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    dp_cmd.capture = accept;
    dp_cmd.step    = rtccsa_pkg::STEP_NONE;
    dp_cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_cmd == rtccsa_pkg::CMD_TICK) ? ST_DAYS : ST_FIN;
        end
      end
      ST_DAYS: begin
        dp_cmd.step = rtccsa_pkg::STEP_DAYS;
        state_nxt   = ST_HRS;
      end
      ST_HRS: begin
        dp_cmd.step = rtccsa_pkg::STEP_HRS;
        state_nxt   = ST_MIN;
      end
      ST_MIN: begin
        dp_cmd.step = rtccsa_pkg::STEP_MIN;
        state_nxt   = ST_SEC;
      end
      ST_SEC: begin
        dp_cmd.step = rtccsa_pkg::STEP_SEC;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        // wait here until the output register can take the result
        if (slot_free) begin
          dp_cmd.commit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/rtccsa_dp.sv
// ----------------------------------------------------------------------------
// rtccsa_dp
// Register file, date-to-seconds accumulator and result register.
// ----------------------------------------------------------------------------
module rtccsa_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rtccsa_pkg::dp_cmd_t dp_cmd,
  input  logic [1:0]         in_cmd,
  input  logic [79:0]        in_data,
  output logic [31:0]        read_data,
  output logic               irq
);

  // latched transaction
  logic [1:0]  cmd_r;
  logic [7:0]  off_r;
  logic [31:0] wdata_r;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;

  logic [31:0] acc_r, acc_nxt;
  logic [31:0] regs_r   [rtccsa_pkg::WORD_COUNT];
  logic [31:0] regs_nxt [rtccsa_pkg::WORD_COUNT];
  logic [31:0] rdata_r, rdata_nxt;
  logic        irq_r, irq_nxt;

  // date decode
  logic [11:0] yrel;
  logic [3:0]  mon;
  logic        leap_add;
  logic [31:0] day_base;

  // address decode
  logic [31:0]                   idx_full;
  logic [rtccsa_pkg::IDX_W-1:0]  idx;
  logic                          in_range;
  logic [31:0]                   ctrl;

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r    <= in_cmd;
      off_r    <= in_data[7:0];
      wdata_r  <= in_data[39:8];
      year_r   <= in_data[51:40];
      month_r  <= in_data[55:52];
      day_r    <= in_data[60:56];
      hour_r   <= in_data[65:61];
      minute_r <= in_data[71:66];
      second_r <= in_data[77:72];
    end
  end

  always_comb begin
    yrel = (year_r < rtccsa_pkg::BASE_YEAR) ? 12'd0 : (year_r - rtccsa_pkg::BASE_YEAR);
    if (month_r == 4'd0) begin
      mon = 4'd1;
    end else if (month_r > 4'd12) begin
      mon = 4'd12;
    end else begin
      mon = month_r;
    end
    leap_add = (yrel[1:0] == 2'd0) && (mon >= 4'd3);
    day_base = 32'(rtccsa_pkg::days_before_year(yrel[1:0]))
             + 32'(rtccsa_pkg::days_before_month(mon - 4'd1))
             + 32'(leap_add) + 32'(day_r) - 32'd1;
  end

  // one constant multiply per step, registered between steps
  always_comb begin
    acc_nxt = acc_r;
    case (dp_cmd.step)
      rtccsa_pkg::STEP_DAYS: acc_nxt = 32'(yrel[11:2]) * rtccsa_pkg::DAYS_CYCLE + day_base;
      rtccsa_pkg::STEP_HRS:  acc_nxt = acc_r * rtccsa_pkg::HRS_DAY + 32'(hour_r);
      rtccsa_pkg::STEP_MIN:  acc_nxt = acc_r * rtccsa_pkg::MIN_HR + 32'(minute_r);
      rtccsa_pkg::STEP_SEC:  acc_nxt = acc_r * rtccsa_pkg::MIN_HR + 32'(second_r);
      default:               acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign idx_full = 32'(off_r) >> 2;
  assign idx      = idx_full[rtccsa_pkg::IDX_W-1:0];
  assign in_range = (32'(off_r) < 32'(rtccsa_pkg::REGION_BYTES))
                 && (idx_full < 32'(rtccsa_pkg::WORD_COUNT));

  always_comb begin
    for (int i = 0; i < rtccsa_pkg::WORD_COUNT; i++) begin
      regs_nxt[i] = regs_r[i];
    end
    rdata_nxt = rdata_r;
    irq_nxt   = irq_r;
    ctrl      = regs_r[rtccsa_pkg::IDX_CTRL];
    if (dp_cmd.commit) begin
      rdata_nxt = 32'd0;
      irq_nxt   = 1'b0;
      case (cmd_r)
        rtccsa_pkg::CMD_READ: begin
          if (in_range) begin
            if (idx == rtccsa_pkg::IDX_CTRL) begin
              ctrl[rtccsa_pkg::BIT_WRDY] = 1'b1;
              regs_nxt[rtccsa_pkg::IDX_CTRL] = ctrl;
              rdata_nxt = ctrl;
            end else begin
              rdata_nxt = regs_r[idx];
            end
          end
        end
        rtccsa_pkg::CMD_WRITE: begin
          if (in_range) begin
            regs_nxt[idx] = wdata_r;
          end
        end
        rtccsa_pkg::CMD_TICK: begin
          if (ctrl[rtccsa_pkg::BIT_EN]) begin
            ctrl[rtccsa_pkg::BIT_HZ] = 1'b1;
            irq_nxt = ctrl[rtccsa_pkg::BIT_HZIE];
            regs_nxt[rtccsa_pkg::IDX_SECS] = acc_r;
            if ((acc_r == regs_r[rtccsa_pkg::IDX_ALARM]) && ctrl[rtccsa_pkg::BIT_AE]) begin
              ctrl[rtccsa_pkg::BIT_AF] = 1'b1;
              irq_nxt = irq_nxt | ctrl[rtccsa_pkg::BIT_AIE];
            end
            regs_nxt[rtccsa_pkg::IDX_CTRL] = ctrl;
          end
        end
        default: begin
          // unused kind: zero result, no side effects
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rtccsa_pkg::WORD_COUNT; i++) begin
        regs_r[i] <= 32'd0;
      end
    end else begin
      for (int i = 0; i < rtccsa_pkg::WORD_COUNT; i++) begin
        regs_r[i] <= regs_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= rdata_nxt;
    irq_r   <= irq_nxt;
  end

  assign read_data = rdata_r;
  assign irq       = irq_r;

endmodule

// File: hw/rtl/rtc_calendar_seconds_alarm.sv
// ----------------------------------------------------------------------------
// rtc_calendar_seconds_alarm
// Real-time clock register block with a seconds counter and an alarm.
// ----------------------------------------------------------------------------
// Usage:
//   One input stream carries three transaction kinds, selected by in_tuser:
//   bus read, bus write, and a once-a-second tick carrying the calendar date.
//   Every accepted transaction yields exactly one output transaction with
//   read_data (zero unless a read) and irq (set when a tick raises the line).
//   Reads/writes go to a 16-word register file (control, seconds, alarm, ...).
// Sequencing:
//   A read or write goes from idle straight to the commit cycle. A tick first
//   runs the date conversion, one constant multiply-add per cycle through a
//   single accumulator (days, hours, minutes, seconds), before the commit cycle.
//   One transaction is in flight at a time; in_tready is high while idle.
// Reset:
//   rst_n (synchronous, active low) clears the register file, the sequencer
//   and the output valid.
// Back-pressure:
//   The result sits in an output register; a new transaction is accepted
//   while it waits. If the next result is ready before out_tready drains the
//   register, the sequencer holds in its commit cycle with nothing modified.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtc_calendar_seconds_alarm (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // byte_offset[7:0], write_data[39:8],
                                  // year[51:40], month[55:52], day[60:56],
                                  // hour[65:61], minute[71:66],
                                  // second[77:72], zero pad [79:78]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // read_data[31:0], irq[32], zero pad [39:33]
);

  rtccsa_pkg::dp_cmd_t dp_cmd;
  logic [31:0]         read_data;
  logic                irq;

  rtccsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .dp_cmd     (dp_cmd)
  );

  rtccsa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_cmd    (dp_cmd),
    .in_cmd    (in_tuser),
    .in_data   (in_tdata),
    .read_data (read_data),
    .irq       (irq)
  );

  assign out_tdata = {7'd0, irq, read_data};

  // one transaction in flight: no accept right after an accept
  `ASSERT_RST(a_single_flight, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)

  // read/write with an empty output register passes the commit state without a stall, then shows its registered result
  `ASSERT_RST(a_rw_latency, clk, rst_n,
    (in_tvalid && in_tready && (in_tuser != rtccsa_pkg::CMD_TICK) && !out_tvalid)
      |-> ##2 out_tvalid)

  // irq only comes from ticks, whose read_data is zero
  `ASSERT_RST(a_irq_no_data, clk, rst_n, (out_tvalid && out_tdata[32]) |-> (out_tdata[31:0] == 32'd0))

endmodule

// File: tb/rtc_calendar_seconds_alarm_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtc_calendar_seconds_alarm_test
// Self-checking bench for the RTC register block. A scoreboard keeps its own
// copy of the register file, works out read data and irq for every accepted
// input transaction, and compares each output transaction in order. Stimulus
// is a directed opener followed by randomized bus traffic and ticks, with
// alarm set-ups that hit and near-miss the converted seconds. Both stream
// sides idle in random bursts, except for a calm stretch at the end.
// ----------------------------------------------------------------------------
module rtc_calendar_seconds_alarm_test;

  // Command code the block leaves unused; must produce an all-zero result
  localparam logic [1:0] CMD_NOP = 2'd3;

  // Total input transactions, directed part included
  localparam int ITEM_TARGET = 550;
  // Idle-free stretch at the end of the run
  localparam int CALM_ITEMS  = 60;

  // One input transaction, field by field
  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  offset;
    logic [31:0] wdata;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } rtc_txn_t;

  // --------------------------------------------------------------------------
  // Scoreboard: register-file shadow plus the queue of expected results
  // --------------------------------------------------------------------------
  class rtc_scoreboard;
    logic [31:0] regs [rtccsa_pkg::WORD_COUNT];
    logic [32:0] result_q [$];     // {irq, read_data}
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    // Seconds since 2000-01-01 00:00:00, every fourth year a leap year,
    // 32-bit wrap on overflow
    static function logic [31:0] calendar_secs(logic [11:0] year, logic [3:0] month,
                                               logic [4:0] day, logic [4:0] hour,
                                               logic [5:0] minute, logic [5:0] second);
      logic [8:0]  month_start [12] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
      logic [31:0] y;
      logic [3:0]  m;
      logic [31:0] t;
      y = (year < rtccsa_pkg::BASE_YEAR) ? 32'd0 : 32'(year - rtccsa_pkg::BASE_YEAR);
      if (month < 4'd1)
        m = 4'd1;
      else if (month > 4'd12)
        m = 4'd12;
      else
        m = month;
      t = (y / 32'd4) * rtccsa_pkg::DAYS_CYCLE;
      if (y[1:0] != 2'd0) t = t + 32'd365 * y[1:0] + 32'd1;  // leap year leads the cycle
      t = t + month_start[m - 4'd1];
      if (y[1:0] == 2'd0 && m >= 4'd3) t = t + 32'd1;
      t = t + day - 32'd1;
      t = t * rtccsa_pkg::HRS_DAY + hour;
      t = t * rtccsa_pkg::MIN_HR + minute;
      t = t * rtccsa_pkg::MIN_HR + second;
      return t;
    endfunction

    // Accepted input transaction: update shadow state, queue the result
    function void note(logic [1:0] cmd, logic [79:0] d);
      logic [7:0]  off;
      logic [31:0] rdata;
      logic [31:0] secs;
      logic        irq;
      int          idx;
      off   = d[7:0];
      idx   = off >> 2;
      rdata = '0;
      irq   = 1'b0;
      case (cmd)
        rtccsa_pkg::CMD_READ: begin
          if (off < rtccsa_pkg::REGION_BYTES && idx < rtccsa_pkg::WORD_COUNT) begin
            if (idx == rtccsa_pkg::IDX_CTRL)
              regs[rtccsa_pkg::IDX_CTRL][rtccsa_pkg::BIT_WRDY] = 1'b1;
            rdata = regs[idx];
          end
        end
        rtccsa_pkg::CMD_WRITE: begin
          if (off < rtccsa_pkg::REGION_BYTES && idx < rtccsa_pkg::WORD_COUNT)
            regs[idx] = d[39:8];
        end
        rtccsa_pkg::CMD_TICK: begin
          if (regs[rtccsa_pkg::IDX_CTRL][rtccsa_pkg::BIT_EN]) begin
            regs[rtccsa_pkg::IDX_CTRL][rtccsa_pkg::BIT_HZ] = 1'b1;
            if (regs[rtccsa_pkg::IDX_CTRL][rtccsa_pkg::BIT_HZIE]) irq = 1'b1;
            secs = calendar_secs(d[51:40], d[55:52], d[60:56], d[65:61], d[71:66],
                                 d[77:72]);
            regs[rtccsa_pkg::IDX_SECS] = secs;
            if (secs == regs[rtccsa_pkg::IDX_ALARM] &&
                regs[rtccsa_pkg::IDX_CTRL][rtccsa_pkg::BIT_AE]) begin
              regs[rtccsa_pkg::IDX_CTRL][rtccsa_pkg::BIT_AF] = 1'b1;
              if (regs[rtccsa_pkg::IDX_CTRL][rtccsa_pkg::BIT_AIE]) irq = 1'b1;
            end
          end
        end
        default: ;
      endcase
      result_q.push_back({irq, rdata});
    endfunction

    // Output transaction against the oldest expectation
    function void check(logic [31:0] rdata, logic irq);
      logic [32:0] want;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing pending: read_data=%h irq=%b", $realtime,
                   rdata, irq);
        return;
      end
      want = result_q.pop_front();
      if (want[31:0] !== rdata || want[32] !== irq) begin
        errors++;
        if (errors <= 10)
          $display("%0t: read_data exp %h got %h, irq exp %b got %b", $realtime,
                   want[31:0], rdata, want[32], irq);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata   = '0;   // byte_offset, write_data, year, month, day,
                                  // hour, minute, second, zero pad (low bit up)
  logic [1:0]  in_tuser   = '0;   // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // read_data, irq, zero pad (low bit up)

  rtc_scoreboard sb;
  int            sent;
  bit            quiet;           // no idling on either side once set

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  rtc_calendar_seconds_alarm u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Monitor: results are checked before the same-edge input is noted, since a
  // result always belongs to an earlier transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check(out_tdata[31:0], out_tdata[32]);
      if (in_tvalid && in_tready) sb.note(in_tuser, in_tdata);
    end
  end

  // Result side back-pressure: random stall bursts
  always begin
    @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Transaction builders
  // --------------------------------------------------------------------------
  // Every field random, so all bits of all fields toggle even where unused
  function automatic rtc_txn_t noise_txn();
    rtc_txn_t t;
    t.cmd    = 2'($urandom_range(0, 3));
    t.offset = 8'($urandom);
    t.wdata  = $urandom;
    t.year   = 12'($urandom);
    t.month  = 4'($urandom);
    t.day    = 5'($urandom);
    t.hour   = 5'($urandom);
    t.minute = 6'($urandom);
    t.second = 6'($urandom);
    return t;
  endfunction

  function automatic rtc_txn_t bus_txn(logic [1:0] cmd, logic [7:0] off, logic [31:0] wdata);
    rtc_txn_t t;
    t        = noise_txn();
    t.cmd    = cmd;
    t.offset = off;
    t.wdata  = wdata;
    return t;
  endfunction

  function automatic rtc_txn_t tick_txn(logic [11:0] y, logic [3:0] m, logic [4:0] d,
                                        logic [4:0] h, logic [5:0] mi, logic [5:0] s);
    rtc_txn_t t;
    t        = noise_txn();
    t.cmd    = rtccsa_pkg::CMD_TICK;
    t.year   = y;
    t.month  = m;
    t.day    = d;
    t.hour   = h;
    t.minute = mi;
    t.second = s;
    return t;
  endfunction

  // Mostly plausible calendar dates, one in five with raw field values
  function automatic rtc_txn_t random_tick();
    rtc_txn_t t;
    t = noise_txn();
    t.cmd = rtccsa_pkg::CMD_TICK;
    if ($urandom_range(0, 4) != 0) begin
      t.year   = 12'($urandom_range(1995, 2110));
      t.month  = 4'($urandom_range(1, 12));
      t.day    = 5'($urandom_range(1, 31));
      t.hour   = 5'($urandom_range(0, 23));
      t.minute = 6'($urandom_range(0, 59));
      t.second = 6'($urandom_range(0, 60));
    end
    return t;
  endfunction

  function automatic logic [31:0] tick_secs(rtc_txn_t t);
    return rtc_scoreboard::calendar_secs(t.year, t.month, t.day, t.hour, t.minute,
                                         t.second);
  endfunction

  // Drive one transaction and hold it until accepted; optional idle burst
  // first. tvalid stays high between back-to-back transactions.
  task automatic send_txn(input rtc_txn_t t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= t.cmd;
    in_tdata  <= {2'b00, t.second, t.minute, t.hour, t.day, t.month, t.year,
                  t.wdata, t.offset};
    do @(posedge clk); while (!in_tready);
    sent++;
    if (sent >= ITEM_TARGET - CALM_ITEMS) quiet = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rtc_txn_t    tk;
    logic [31:0] alarm;
    logic [31:0] ctrl;
    int          pick;

    sb    = new();
    sent  = 0;
    quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed opener ----
    // control read right after reset returns only the write-ready bit
    send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd0, 32'h0));
    // offset past the region: read returns zero, write is dropped
    send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd255, 32'h0));
    send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd64, 32'hFFFF_FFFF));
    // unaligned offset lands on the last word
    send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd63, 32'hFFFF_FFFF));
    send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd61, 32'h0));
    send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd60, 32'h0000_0000));
    // unused command with every field at its top value
    tk = tick_txn(12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F);
    tk.cmd = CMD_NOP;
    tk.offset = 8'hFF;
    tk.wdata = 32'hFFFF_FFFF;
    send_txn(tk);
    // tick with the block disabled leaves seconds alone
    send_txn(tick_txn(12'd2024, 4'd6, 5'd15, 5'd10, 6'd30, 6'd0));
    send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd4, 32'h0));
    // enable with 1 Hz interrupt; year below 2000, month 0 and day 0
    send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd0,
                     32'(1 << rtccsa_pkg::BIT_EN | 1 << rtccsa_pkg::BIT_HZIE)));
    send_txn(tick_txn(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0));
    send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd4, 32'h0));
    // all fields at their top values: month clamped, seconds wrap
    send_txn(tick_txn(12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F));
    send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd5, 32'h0));
    send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd0, 32'h0));
    // alarm on a leap day, alarm interrupt only
    send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd0,
                     32'(1 << rtccsa_pkg::BIT_EN | 1 << rtccsa_pkg::BIT_AE |
                         1 << rtccsa_pkg::BIT_AIE)));
    tk = tick_txn(12'd2024, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0);
    send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd8, tick_secs(tk)));
    send_txn(tk);
    send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd0, 32'h0));
    // alarm match without alarm interrupt: flag only, across the leap day
    send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd0,
                     32'(1 << rtccsa_pkg::BIT_EN | 1 << rtccsa_pkg::BIT_AE)));
    tk = tick_txn(12'd2023, 4'd3, 5'd1, 5'd23, 6'd59, 6'd60);
    send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd8, tick_secs(tk)));
    send_txn(tk);
    send_txn(tick_txn(12'd2024, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
    // every control bit set, then read back
    send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd0, 32'hFFFF_FFFF));
    send_txn(tick_txn(12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
    send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd0, 32'h0));

    // ---- randomized traffic ----
    while (sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // control write, usually enabled, flags cleared at random
        ctrl = $urandom;
        ctrl[rtccsa_pkg::BIT_EN] = ($urandom_range(0, 4) != 0);
        send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd0, ctrl));
      end else if (pick < 28) begin
        // alarm set-up: hit, or miss by one second
        tk = random_tick();
        alarm = tick_secs(tk);
        if ($urandom_range(0, 5) == 0) alarm = alarm + 32'd1;
        send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'd8 | 8'($urandom_range(0, 3)), alarm));
        if ($urandom_range(0, 2) == 0)
          send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd0, 32'h0));
        send_txn(tk);
        if ($urandom_range(0, 3) == 0) send_txn(tk);
        send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'd0, 32'h0));
      end else if (pick < 50) begin
        send_txn(random_tick());
      end else if (pick < 68) begin
        // read of the live registers
        send_txn(bus_txn(rtccsa_pkg::CMD_READ,
                         8'(4 * $urandom_range(0, 2) + $urandom_range(0, 3)), $urandom));
      end else if (pick < 82) begin
        send_txn(bus_txn(rtccsa_pkg::CMD_WRITE, 8'($urandom), $urandom));
      end else if (pick < 95) begin
        send_txn(bus_txn(rtccsa_pkg::CMD_READ, 8'($urandom), $urandom));
      end else begin
        tk = noise_txn();
        tk.cmd = CMD_NOP;
        send_txn(tk);
      end
    end
    in_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (sb.errors == 0 && sb.result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rtccsa_pkg.sv
hw/rtl/rtccsa_ctrl.sv
hw/rtl/rtccsa_dp.sv
hw/rtl/rtc_calendar_seconds_alarm.sv
tb/rtc_calendar_seconds_alarm_test.sv
